// ----- hdl/lod_pkg.sv -----
// shared types, register codes and reset values for the lift-off detector
package lod_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEVEL_ANGLE   = 3'd0,
        REG_STILL_LIMIT   = 3'd1,
        REG_STILL_SAMPLES = 3'd2,
        REG_LIFT_ACCEL    = 3'd3,
        REG_ANGLE_WINDOW  = 3'd4,
        REG_SPIN_LIMIT    = 3'd5,
        REG_LIFT_TIMEOUT  = 3'd6,
        REG_SPIN_TIMEOUT  = 3'd7
    } lod_reg_t;

    typedef enum logic [2:0] {
        STAGE_STILL = 3'b001,
        STAGE_LIFT  = 3'b010,
        STAGE_SPIN  = 3'b100
    } lod_stage_t;

    typedef struct packed {
        logic signed [15:0] level_angle;
        logic [15:0]        still_limit;
        logic [15:0]        still_samples;
        logic signed [15:0] lift_accel;
        logic [14:0]        angle_window;
        logic [16:0]        spin_limit;
        logic [15:0]        lift_timeout;
        logic [15:0]        spin_timeout;
    } lod_cfg_t;

    typedef struct packed {
        lod_stage_t  stage;
        logic [15:0] still_run;
        logic [15:0] lift_timer;
        logic [15:0] spin_timer;
    } lod_state_t;

    localparam logic signed [15:0] RST_LEVEL_ANGLE   = 16'sd0;
    localparam logic [15:0]        RST_STILL_LIMIT   = 16'd50;
    localparam logic [15:0]        RST_STILL_SAMPLES = 16'd10;
    localparam logic signed [15:0] RST_LIFT_ACCEL    = 16'sd26000;
    localparam logic [14:0]        RST_ANGLE_WINDOW  = 15'd2000;
    localparam logic [16:0]        RST_SPIN_LIMIT    = 17'd135;
    localparam logic [15:0]        RST_LIFT_TIMEOUT  = 16'd200;
    localparam logic [15:0]        RST_SPIN_TIMEOUT  = 16'd100;

endpackage

// ----- hdl/lift_off_detector.sv -----
// top level of the lift-off detector: input register, stage update and result register
// Takes one sensor sample per transaction and returns one picked_up result for each,
// in order. A sample sits in the input register while the stage logic evaluates it
// against the detector state and writes the result register, so the block accepts a
// new transaction every cycle while the output side is not stalled; each sample passes
// through the input register and its result through the result register. Configuration
// writes are taken at any time but are meant for idle.
module lift_off_detector
    import lod_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [15:0]     s_accel,
    input  logic signed [15:0]     s_tilt_angle,
    input  logic signed [15:0]     s_enc_left,
    input  logic signed [15:0]     s_enc_right,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_picked_up
);

    lod_cfg_t           cfg;
    lod_state_t         state_reg;
    lod_state_t         state_next;
    logic               hit;
    logic               in_valid_reg;
    logic signed [15:0] accel_reg;
    logic signed [15:0] tilt_angle_reg;
    logic signed [15:0] enc_left_reg;
    logic signed [15:0] enc_right_reg;
    logic               out_valid_reg;
    logic               picked_up_reg;
    logic               advance;

    lod_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lod_eval u_eval (
        .cfg        (cfg),
        .state      (state_reg),
        .accel      (accel_reg),
        .tilt_angle (tilt_angle_reg),
        .enc_left   (enc_left_reg),
        .enc_right  (enc_right_reg),
        .state_next (state_next),
        .hit        (hit)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            accel_reg      <= s_accel;
            tilt_angle_reg <= s_tilt_angle;
            enc_left_reg   <= s_enc_left;
            enc_right_reg  <= s_enc_right;
        end
    end

    // detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.stage      <= STAGE_STILL;
            state_reg.still_run  <= 16'd0;
            state_reg.lift_timer <= 16'd0;
            state_reg.spin_timer <= 16'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            picked_up_reg <= hit;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_picked_up = picked_up_reg;

endmodule

// ----- hdl/lod_cfg.sv -----
// configuration register file of the lift-off detector
module lod_cfg
    import lod_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output lod_cfg_t               cfg
);

    lod_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_angle   <= RST_LEVEL_ANGLE;
            cfg_reg.still_limit   <= RST_STILL_LIMIT;
            cfg_reg.still_samples <= RST_STILL_SAMPLES;
            cfg_reg.lift_accel    <= RST_LIFT_ACCEL;
            cfg_reg.angle_window  <= RST_ANGLE_WINDOW;
            cfg_reg.spin_limit    <= RST_SPIN_LIMIT;
            cfg_reg.lift_timeout  <= RST_LIFT_TIMEOUT;
            cfg_reg.spin_timeout  <= RST_SPIN_TIMEOUT;
        end else if (cfg_wr_en) begin
            case (lod_reg_t'(cfg_index))
                REG_LEVEL_ANGLE:   cfg_reg.level_angle   <= $signed(cfg_data[15:0]);
                REG_STILL_LIMIT:   cfg_reg.still_limit   <= cfg_data[15:0];
                REG_STILL_SAMPLES: cfg_reg.still_samples <= cfg_data[15:0];
                REG_LIFT_ACCEL:    cfg_reg.lift_accel    <= $signed(cfg_data[15:0]);
                REG_ANGLE_WINDOW:  cfg_reg.angle_window  <= cfg_data[14:0];
                REG_SPIN_LIMIT:    cfg_reg.spin_limit    <= cfg_data[16:0];
                REG_LIFT_TIMEOUT:  cfg_reg.lift_timeout  <= cfg_data[15:0];
                REG_SPIN_TIMEOUT:  cfg_reg.spin_timeout  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/lod_eval.sv -----
// combinational evaluation of the three detector stages with fall-through
module lod_eval
    import lod_pkg::*;
(
    input  lod_cfg_t           cfg,
    input  lod_state_t         state,
    input  logic signed [15:0] accel,
    input  logic signed [15:0] tilt_angle,
    input  logic signed [15:0] enc_left,
    input  logic signed [15:0] enc_right,
    output lod_state_t         state_next,
    output logic               hit
);

    logic [15:0]        mag_left;
    logic [15:0]        mag_right;
    logic [16:0]        still_sum;
    logic [16:0]        enc_sum;
    logic [16:0]        spin_mag;
    logic signed [17:0] level_x;
    logic signed [17:0] window_x;
    logic signed [17:0] tilt_x;
    logic signed [17:0] win_lo;
    logic signed [17:0] win_hi;
    logic               is_still;
    logic               lift_seen;

    always_comb begin
        mag_left  = enc_left[15] ? (~enc_left + 16'd1) : enc_left;
        mag_right = enc_right[15] ? (~enc_right + 16'd1) : enc_right;
        still_sum = {1'b0, mag_left} + {1'b0, mag_right};
        is_still  = still_sum < {1'b0, cfg.still_limit};

        enc_sum  = {enc_left[15], enc_left} + {enc_right[15], enc_right};
        spin_mag = enc_sum[16] ? (~enc_sum + 17'd1) : enc_sum;

        level_x   = {{2{cfg.level_angle[15]}}, cfg.level_angle};
        window_x  = {3'b000, cfg.angle_window};
        tilt_x    = {{2{tilt_angle[15]}}, tilt_angle};
        win_lo    = level_x - window_x;
        win_hi    = level_x + window_x;
        lift_seen = (accel > cfg.lift_accel) && (tilt_x > win_lo) && (tilt_x < win_hi);
    end

    always_comb begin
        state_next = state;
        hit        = 1'b0;

        // still detection
        if (state_next.stage == STAGE_STILL) begin
            state_next.still_run = is_still ? (state_next.still_run + 16'd1) : 16'd0;
            if (state_next.still_run > cfg.still_samples) begin
                state_next.stage     = STAGE_LIFT;
                state_next.still_run = 16'd0;
            end
        end

        // waiting for the lift
        if (state_next.stage == STAGE_LIFT) begin
            state_next.lift_timer = state_next.lift_timer + 16'd1;
            if (state_next.lift_timer > cfg.lift_timeout) begin
                state_next.lift_timer = 16'd0;
                state_next.stage      = STAGE_STILL;
            end
            if (lift_seen) begin
                state_next.stage = STAGE_SPIN;
            end
        end

        // waiting for free wheel spin
        if (state_next.stage == STAGE_SPIN) begin
            state_next.spin_timer = state_next.spin_timer + 16'd1;
            if (state_next.spin_timer > cfg.spin_timeout) begin
                state_next.spin_timer = 16'd0;
                state_next.stage      = STAGE_STILL;
            end
            if (spin_mag > cfg.spin_limit) begin
                state_next.stage = STAGE_STILL;
                hit              = 1'b1;
            end
        end
    end

endmodule

// ----- tb/lift_off_detector_test.sv -----
// self-checking testbench for the lift-off detector: directed table, then randomised phases
module lift_off_detector_test;
    import lod_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 165;
    localparam int MAX_PRINTS  = 40;

    localparam logic [1:0] WANT_ZERO      = 2'd0;
    localparam logic [1:0] WANT_ONE       = 2'd1;
    localparam logic [1:0] WANT_PREDICTED = 2'd2;

    typedef struct {
        logic signed [15:0] accel;
        logic signed [15:0] tilt_angle;
        logic signed [15:0] enc_left;
        logic signed [15:0] enc_right;
    } lift_sample_t;

    typedef struct packed {
        logic signed [15:0] accel;
        logic signed [15:0] tilt_angle;
        logic signed [15:0] enc_left;
        logic signed [15:0] enc_right;
        logic [1:0]         want;
    } directed_row_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    localparam int DIRECTED_COUNT = 21;
    localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        '{ 16'sd32767,  16'sd18000,  16'sh8000,   16'sh8000,   WANT_ZERO },
        '{ 16'sh8000,  -16'sd18000,  16'sd32767,  16'sd32767,  WANT_ZERO },
        '{ 16'sd0,      16'sd0,      16'sd0,      16'sd0,      WANT_PREDICTED },
        '{ 16'sd100,   -16'sd50,     16'sd49,     16'sd0,      WANT_PREDICTED },
        '{ 16'sd0,      16'sd0,      16'sd25,    -16'sd25,     WANT_PREDICTED },
        '{ 16'sd1200,   16'sd300,   -16'sd24,     16'sd25,     WANT_PREDICTED },
        '{-16'sd500,   -16'sd700,    16'sd10,     16'sd10,     WANT_PREDICTED },
        '{ 16'sd0,      16'sd0,      16'sd0,     -16'sd49,     WANT_PREDICTED },
        '{ 16'sd20000,  16'sd1500,   16'sd3,     -16'sd3,      WANT_PREDICTED },
        '{ 16'sd0,      16'sd0,      16'sd48,     16'sd1,      WANT_PREDICTED },
        '{ 16'sd32767,  16'sd0,     -16'sd20,    -16'sd20,     WANT_PREDICTED },
        '{ 16'sh8000,   16'sd18000,  16'sd1,      16'sd1,      WANT_PREDICTED },
        '{ 16'sd30000, -16'sd18000,  16'sd0,      16'sd0,      WANT_PREDICTED },
        '{ 16'sd0,      16'sd5000,  -16'sd30,     16'sd18,     WANT_PREDICTED },
        '{ 16'sd500,    16'sd0,      16'sd7,      16'sd7,      WANT_PREDICTED },
        '{ 16'sd26000,  16'sd0,      16'sd0,      16'sd0,      WANT_PREDICTED },
        '{ 16'sd26001,  16'sd2000,   16'sd0,      16'sd0,      WANT_PREDICTED },
        '{ 16'sd26001, -16'sd1999,   16'sd100,    16'sd35,     WANT_PREDICTED },
        '{ 16'sd0,      16'sd0,      16'sd100,    16'sd36,     WANT_PREDICTED },
        '{ 16'sd0,      16'sd0,      16'sd32767,  16'sh8000,   WANT_PREDICTED },
        '{ 16'sd0,      16'sd0,      16'sh8000,   16'sd0,      WANT_PREDICTED }
    };

    localparam lod_cfg_t CFG_FLOOR = '{
        level_angle: -16'sd18000, still_limit: 16'd0, still_samples: 16'd0,
        lift_accel: 16'sh8000, angle_window: 15'd0, spin_limit: 17'd0,
        lift_timeout: 16'd0, spin_timeout: 16'd0
    };
    localparam lod_cfg_t CFG_CEILING = '{
        level_angle: 16'sd18000, still_limit: 16'hFFFF, still_samples: 16'hFFFF,
        lift_accel: 16'sh7FFF, angle_window: 15'd18000, spin_limit: 17'd131070,
        lift_timeout: 16'd65534, spin_timeout: 16'd65534
    };
    localparam lod_cfg_t CFG_WIDE_OPEN = '{
        level_angle: 16'sd0, still_limit: 16'hFFFF, still_samples: 16'd0,
        lift_accel: 16'sh8000, angle_window: 15'd18000, spin_limit: 17'd0,
        lift_timeout: 16'd65534, spin_timeout: 16'd65534
    };

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [15:0]     s_accel = '0;
    logic signed [15:0]     s_tilt_angle = '0;
    logic signed [15:0]     s_enc_left = '0;
    logic signed [15:0]     s_enc_right = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_picked_up;

    // predictor copy of registers and detector state
    lod_cfg_t   thresholds;
    lod_stage_t det_stage;
    logic [15:0] still_run;
    logic [15:0] lift_timer;
    logic [15:0] spin_timer;

    logic        pickup_due[$];
    int          mismatches = 0;
    int          burst_left = 0;
    logic        due_bit;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          ready_left = 0;

    lift_off_detector i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_accel     (s_accel),
        .s_tilt_angle(s_tilt_angle),
        .s_enc_left  (s_enc_left),
        .s_enc_right (s_enc_right),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_picked_up (m_picked_up)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("[lift_off_detector] ERROR");
        $finish;
    end

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic detect_pickup(input lift_sample_t smp);
        int  accel, tilt, left, right, lvl, win;
        logic hit;
        accel = smp.accel;
        tilt  = smp.tilt_angle;
        left  = smp.enc_left;
        right = smp.enc_right;
        lvl   = $signed(thresholds.level_angle);
        win   = int'(thresholds.angle_window);
        hit   = 1'b0;
        if (det_stage == STAGE_STILL) begin
            if (abs_int(left) + abs_int(right) < int'(thresholds.still_limit)) begin
                still_run = still_run + 16'd1;
            end else begin
                still_run = '0;
            end
            if (still_run > thresholds.still_samples) begin
                det_stage = STAGE_LIFT;
                still_run = '0;
            end
        end
        if (det_stage == STAGE_LIFT) begin
            lift_timer = lift_timer + 16'd1;
            if (lift_timer > thresholds.lift_timeout) begin
                lift_timer = '0;
                det_stage  = STAGE_STILL;
            end
            if (accel > int'($signed(thresholds.lift_accel)) &&
                tilt > lvl - win && tilt < lvl + win) begin
                det_stage = STAGE_SPIN;
            end
        end
        if (det_stage == STAGE_SPIN) begin
            spin_timer = spin_timer + 16'd1;
            if (spin_timer > thresholds.spin_timeout) begin
                spin_timer = '0;
                det_stage  = STAGE_STILL;
            end
            if (abs_int(left + right) > int'(thresholds.spin_limit)) begin
                det_stage = STAGE_STILL;
                hit       = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic lift_sample_t noise_sample();
        lift_sample_t s;
        s.accel      = 16'($urandom);
        s.tilt_angle = 16'(int'($urandom_range(0, 36000)) - 18000);
        s.enc_left   = 16'($urandom);
        s.enc_right  = 16'($urandom);
        return s;
    endfunction

    function automatic lift_sample_t quiet_sample();
        lift_sample_t s;
        s           = noise_sample();
        s.enc_left  = 16'(int'($urandom_range(0, 300)) - 150);
        s.enc_right = 16'(int'($urandom_range(0, 300)) - 150);
        return s;
    endfunction

    function automatic lift_sample_t still_sample();
        lift_sample_t s;
        int total, lo, hi, a, b;
        s = noise_sample();
        if (thresholds.still_limit == 16'd0) return s;
        total = int'($urandom_range(0, int'(thresholds.still_limit) - 1));
        lo    = (total > 32767) ? total - 32767 : 0;
        hi    = (total < 32767) ? total : 32767;
        a     = int'($urandom_range(lo, hi));
        b     = total - a;
        s.enc_left  = 16'($urandom_range(0, 1) ? -a : a);
        s.enc_right = 16'($urandom_range(0, 1) ? -b : b);
        return s;
    endfunction

    function automatic lift_sample_t lift_sample();
        lift_sample_t s, n;
        int acc, lvl, win, lo, hi;
        s   = quiet_sample();
        n   = noise_sample();
        acc = $signed(thresholds.lift_accel);
        lvl = $signed(thresholds.level_angle);
        win = int'(thresholds.angle_window);
        if (acc < 32767) s.accel = 16'(acc + 1 + int'($urandom_range(0, 32766 - acc)));
        lo = (lvl - win + 1 > -18000) ? lvl - win + 1 : -18000;
        hi = (lvl + win - 1 < 18000) ? lvl + win - 1 : 18000;
        if (lo <= hi) s.tilt_angle = 16'(lo + int'($urandom_range(0, hi - lo)));
        if ($urandom_range(0, 2) == 0) begin
            s.enc_left  = n.enc_left;
            s.enc_right = n.enc_right;
        end
        return s;
    endfunction

    function automatic lift_sample_t spin_sample();
        lift_sample_t s;
        int m, total, lo, hi, l;
        s = quiet_sample();
        if (thresholds.spin_limit >= 17'd65536) return s;
        m = int'(thresholds.spin_limit) + 1 + int'($urandom_range(0, 200));
        if (m > 65536) m = 65536;
        total = (m <= 65534 && $urandom_range(0, 1) == 1) ? m : -m;
        lo    = (total - 32767 > -32768) ? total - 32767 : -32768;
        hi    = (total + 32768 < 32767) ? total + 32768 : 32767;
        l     = lo + int'($urandom_range(0, hi - lo));
        s.enc_left  = 16'(l);
        s.enc_right = 16'(total - l);
        return s;
    endfunction

    function automatic lod_cfg_t random_cfg();
        lod_cfg_t c;
        c.level_angle   = 16'(int'($urandom_range(0, 36000)) - 18000);
        c.still_limit   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(1, 400));
        c.still_samples = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 12));
        c.lift_accel    = 16'(int'($urandom_range(0, 62000)) - 32768);
        c.angle_window  = 15'($urandom_range(0, 18000));
        c.spin_limit    = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131070))
                                                       : 17'($urandom_range(0, 3000));
        c.lift_timeout  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65534))
                                                       : 16'($urandom_range(0, 30));
        c.spin_timeout  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65534))
                                                       : 16'($urandom_range(0, 30));
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic write_reg(input lod_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_LEVEL_ANGLE:   thresholds.level_angle   = data[15:0];
            REG_STILL_LIMIT:   thresholds.still_limit   = data[15:0];
            REG_STILL_SAMPLES: thresholds.still_samples = data[15:0];
            REG_LIFT_ACCEL:    thresholds.lift_accel    = data[15:0];
            REG_ANGLE_WINDOW:  thresholds.angle_window  = data[14:0];
            REG_SPIN_LIMIT:    thresholds.spin_limit    = data[16:0];
            REG_LIFT_TIMEOUT:  thresholds.lift_timeout  = data[15:0];
            default:           thresholds.spin_timeout  = data[15:0];
        endcase
        @(posedge aclk);
    endtask

    // unused upper bits carry junk, the block must mask them
    task automatic write_cfg(input lod_cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_LEVEL_ANGLE,   {junk[16], c.level_angle});
        write_reg(REG_STILL_LIMIT,   {junk[16], c.still_limit});
        write_reg(REG_STILL_SAMPLES, {junk[16], c.still_samples});
        write_reg(REG_LIFT_ACCEL,    {junk[16], c.lift_accel});
        write_reg(REG_ANGLE_WINDOW,  {junk[16:15], c.angle_window});
        write_reg(REG_SPIN_LIMIT,    c.spin_limit);
        write_reg(REG_LIFT_TIMEOUT,  {junk[16], c.lift_timeout});
        write_reg(REG_SPIN_TIMEOUT,  {junk[16], c.spin_timeout});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample(input lift_sample_t smp);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            burst_left = int'($urandom_range(1, 24));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid      <= 1'b1;
        s_accel      <= smp.accel;
        s_tilt_angle <= smp.tilt_angle;
        s_enc_left   <= smp.enc_left;
        s_enc_right  <= smp.enc_right;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pickup_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_left <= int'($urandom_range(20, 80));
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: m_ready <= (ready_left % 5) != 0;
            default:        m_ready <= (ready_left % 16) > 11;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pickup_due.size() == 0) begin
                report_mismatch($sformatf("picked_up=%0b with no transaction pending",
                                          m_picked_up));
            end else begin
                due_bit = pickup_due.pop_front();
                if (m_picked_up !== due_bit) begin
                    report_mismatch($sformatf("picked_up=%0b, predicted %0b",
                                              m_picked_up, due_bit));
                end
            end
        end
    end

    initial begin
        lift_sample_t smp;
        logic         hit;
        lod_cfg_t     c;
        int           pick;

        thresholds = '{
            level_angle: RST_LEVEL_ANGLE, still_limit: RST_STILL_LIMIT,
            still_samples: RST_STILL_SAMPLES, lift_accel: RST_LIFT_ACCEL,
            angle_window: RST_ANGLE_WINDOW, spin_limit: RST_SPIN_LIMIT,
            lift_timeout: RST_LIFT_TIMEOUT, spin_timeout: RST_SPIN_TIMEOUT
        };
        det_stage  = STAGE_STILL;
        still_run  = '0;
        lift_timer = '0;
        spin_timer = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table under reset values
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            smp.accel      = DIRECTED_ROWS[i].accel;
            smp.tilt_angle = DIRECTED_ROWS[i].tilt_angle;
            smp.enc_left   = DIRECTED_ROWS[i].enc_left;
            smp.enc_right  = DIRECTED_ROWS[i].enc_right;
            hit = detect_pickup(smp);
            if (DIRECTED_ROWS[i].want == WANT_PREDICTED) begin
                pickup_due.push_back(hit);
            end else begin
                pickup_due.push_back(DIRECTED_ROWS[i].want == WANT_ONE);
            end
            send_sample(smp);
        end
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                c = CFG_FLOOR;
            end else if (p == 1) begin
                c = CFG_CEILING;
            end else if (p == 2) begin
                c = CFG_WIDE_OPEN;
            end else begin
                c = random_cfg();
            end
            write_cfg(c);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = int'($urandom_range(0, 99));
                case (det_stage)
                    STAGE_STILL: smp = (pick < 80) ? still_sample() :
                                       (pick < 90) ? quiet_sample() : noise_sample();
                    STAGE_LIFT:  smp = (pick < 35) ? lift_sample() :
                                       (pick < 70) ? quiet_sample() : noise_sample();
                    default:     smp = (pick < 35) ? spin_sample() :
                                       (pick < 80) ? quiet_sample() : noise_sample();
                endcase
                pickup_due.push_back(detect_pickup(smp));
                send_sample(smp);
            end
            drain_results();
        end

        if (mismatches == 0) begin
            $display("[lift_off_detector] OK");
        end else begin
            $display("[lift_off_detector] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/lod_pkg.sv
hdl/lod_cfg.sv
hdl/lod_eval.sv
hdl/lift_off_detector.sv
tb/lift_off_detector_test.sv
